### rtl/plt_pkg.sv
package plt_pkg;

    // table sizes and field widths
    localparam int MAX_NODES   = 16;
    localparam int MAX_TRACKED = 16;
    localparam int TIME_WIDTH  = 32;

    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int EP_W   = IP_W + PORT_W;
    localparam int TO_W   = 16;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // index and count widths
    localparam int LIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int SIW = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
    localparam int JW  = (LIW > SIW) ? LIW : SIW;
    localparam int CW  = $clog2(MAX_NODES + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK     = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // compare unit result
    typedef struct packed {
        logic eq;
        logic expired;
    } t_cmp_res;

endpackage

### rtl/plt_in_if.sv
interface plt_in_if;
    import plt_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [IP_W-1:0]   endpoint_ip;
    logic [PORT_W-1:0] endpoint_port;
    modport source(output valid, output operation, output endpoint_ip,
                   output endpoint_port, input ready);
    modport sink(input valid, input operation, input endpoint_ip,
                 input endpoint_port, output ready);
endinterface

### rtl/plt_out_if.sv
interface plt_out_if;
    import plt_pkg::*;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic              alive;
    logic              failed_valid;
    logic [IP_W-1:0]   failed_ip;
    logic [PORT_W-1:0] failed_port;
    logic              last;
    modport source(output valid, output status, output alive, output failed_valid,
                   output failed_ip, output failed_port, output last, input ready);
    modport sink(input valid, input status, input alive, input failed_valid,
                 input failed_ip, input failed_port, input last, output ready);
endinterface

### rtl/plt_cfg_if.sv
interface plt_cfg_if;
    import plt_pkg::*;
    logic            valid;
    logic            ready;
    logic [TO_W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/plt_cmp.sv
module plt_cmp (
    input  logic [plt_pkg::EP_W-1:0]       i_entry_ep,
    input  logic [plt_pkg::EP_W-1:0]       i_key_ep,
    input  logic [plt_pkg::TIME_WIDTH-1:0] i_entry_time,
    input  logic [plt_pkg::TIME_WIDTH-1:0] i_cur_time,
    input  logic [plt_pkg::TO_W-1:0]       i_timeout,
    output plt_pkg::t_cmp_res              o_res
);
    import plt_pkg::*;

    logic [TIME_WIDTH-1:0] age;

    // shared endpoint match and age check, wrapping time
    assign age           = i_cur_time - i_entry_time;
    assign o_res.eq      = (i_entry_ep == i_key_ep);
    assign o_res.expired = (age >= {{(TIME_WIDTH-TO_W){1'b0}}, i_timeout});
endmodule

### rtl/peer_liveness_timeout_table_core.sv
// Peer liveness table: a packed node list and a last-heard table, each of 16 entries,
// walked one entry per cycle by a single shared match and age compare unit. Tick and
// unused codes go straight to the result; add scans the node list, query and heartbeat
// scan the last-heard table, remove does a list scan, a seen scan and a list shift,
// and a check sweep loads each node in turn and scans the last-heard table for it.
// A result word may wait on the receiver.
// A check emits one word per removed failed node, or one plain word if none failed.
// The input is not ready while an item is being worked on; a result word waits in
// an output register. Timeout writes are taken at any time the block is idle.
module peer_liveness_timeout_table_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plt_in_if.sink    i_in,
    plt_out_if.source o_out,
    plt_cfg_if.sink   i_cfg
);
    import plt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LSCAN, S_SSCAN, S_SHIFT, S_CLOAD, S_CDEC, S_CEND, S_RESP
    } t_state;

    t_state r_state;

    // tables
    logic [EP_W-1:0]       r_list_ep [MAX_NODES];
    logic [CW-1:0]         r_count;
    logic [MAX_TRACKED-1:0] r_seen_valid;
    logic [EP_W-1:0]       r_seen_ep [MAX_TRACKED];
    logic [TIME_WIDTH-1:0] r_seen_time [MAX_TRACKED];
    logic [TIME_WIDTH-1:0] r_time;
    logic [TO_W-1:0]       r_timeout;

    // item and scan registers
    logic [OP_W-1:0] r_op;
    logic [EP_W-1:0] r_key;
    logic [JW-1:0]   r_j;
    logic            r_lhit;
    logic [LIW-1:0]  r_lidx;
    logic            r_shit;
    logic            r_sexp;
    logic            r_ffree;
    logic [SIW-1:0]  r_fidx;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_wp;
    logic            r_pend;
    logic [EP_W-1:0] r_pend_ep;
    logic [ST_W-1:0] r_st;
    logic            r_alive;

    // output register
    logic              r_ov;
    logic [ST_W-1:0]   r_o_status;
    logic              r_o_alive;
    logic              r_o_fv;
    logic [EP_W-1:0]   r_o_ep;
    logic              r_o_last;

    logic            in_acc;
    logic            out_free;
    logic [LIW-1:0]  lj;
    logic [SIW-1:0]  sj;
    logic            l_in_range;
    logic            scan_list;
    logic [EP_W-1:0] cmp_entry;
    t_cmp_res        cmp_res;
    logic            l_hit_now;
    logic            s_hit_now;
    logic [CW-1:0]   j_next;
    logic [LIW-1:0]  lj_next;
    logic            fail;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;
    assign lj         = r_j[LIW-1:0];
    assign sj         = r_j[SIW-1:0];
    assign l_in_range = ({{(CW-LIW){1'b0}}, lj} < r_count);
    assign scan_list  = (r_state == S_LSCAN);
    assign cmp_entry  = scan_list ? r_list_ep[lj] : r_seen_ep[sj];
    assign l_hit_now  = l_in_range && cmp_res.eq;
    assign s_hit_now  = r_seen_valid[sj] && cmp_res.eq;
    assign j_next     = {{(CW-LIW){1'b0}}, lj} + CW'(1);
    assign lj_next    = j_next[LIW-1:0];
    assign fail       = r_shit && r_sexp;

    // shared compare unit
    plt_cmp u_cmp (
        .i_entry_ep  (cmp_entry),
        .i_key_ep    (r_key),
        .i_entry_time(r_seen_time[sj]),
        .i_cur_time  (r_time),
        .i_timeout   (r_timeout),
        .o_res       (cmp_res)
    );

    // handshakes and output word
    assign i_in.ready         = (r_state == S_IDLE);
    assign i_cfg.ready        = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.status       = r_o_status;
    assign o_out.alive        = r_o_alive;
    assign o_out.failed_valid = r_o_fv;
    assign o_out.failed_ip    = r_o_ep[EP_W-1:PORT_W];
    assign o_out.failed_port  = r_o_ep[PORT_W-1:0];
    assign o_out.last         = r_o_last;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_seen_valid <= '0;
            r_time       <= '0;
            r_timeout    <= TO_W'(30);
            r_ov         <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout <= i_cfg.data;
            end
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op    <= i_in.operation;
                        r_key   <= {i_in.endpoint_ip, i_in.endpoint_port};
                        r_j     <= '0;
                        r_lhit  <= 1'b0;
                        r_shit  <= 1'b0;
                        r_sexp  <= 1'b0;
                        r_ffree <= 1'b0;
                        r_st    <= ST_OK;
                        r_alive <= 1'b0;
                        case (i_in.operation)
                            OP_ADD, OP_REMOVE:     r_state <= S_LSCAN;
                            OP_HEARTBEAT, OP_QUERY: r_state <= S_SSCAN;
                            OP_TICK: begin
                                r_time  <= r_time + TIME_WIDTH'(1);
                                r_state <= S_RESP;
                            end
                            OP_CHECK: begin
                                r_i     <= '0;
                                r_wp    <= '0;
                                r_pend  <= 1'b0;
                                r_state <= (r_count == '0) ? S_CEND : S_CLOAD;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_LSCAN: begin
                    if (l_hit_now || lj == LIW'(MAX_NODES - 1)) begin
                        r_j <= '0;
                        if (r_op == OP_ADD) begin
                            r_state <= S_RESP;
                            if (l_hit_now) begin
                                r_st <= ST_DUPLICATE;
                            end else if (r_count == CW'(MAX_NODES)) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_list_ep[r_count[LIW-1:0]] <= r_key;
                                r_count <= r_count + CW'(1);
                            end
                        end else begin
                            r_lhit  <= l_hit_now;
                            r_lidx  <= lj;
                            r_state <= S_SSCAN;
                        end
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_SSCAN: begin
                    if (!r_seen_valid[sj] && !r_ffree) begin
                        r_ffree <= 1'b1;
                        r_fidx  <= sj;
                    end
                    if (s_hit_now || sj == SIW'(MAX_TRACKED - 1)) begin
                        r_shit <= s_hit_now;
                        r_sexp <= cmp_res.expired;
                        case (r_op)
                            OP_HEARTBEAT: begin
                                r_state <= S_RESP;
                                if (s_hit_now) begin
                                    r_seen_time[sj] <= r_time;
                                end else if (r_ffree || !r_seen_valid[sj]) begin
                                    r_seen_valid[r_ffree ? r_fidx : sj] <= 1'b1;
                                    r_seen_ep[r_ffree ? r_fidx : sj]    <= r_key;
                                    r_seen_time[r_ffree ? r_fidx : sj]  <= r_time;
                                end else begin
                                    r_st <= ST_FULL;
                                end
                            end
                            OP_QUERY: begin
                                r_alive <= !s_hit_now || !cmp_res.expired;
                                r_state <= S_RESP;
                            end
                            OP_REMOVE: begin
                                if (s_hit_now) begin
                                    r_seen_valid[sj] <= 1'b0;
                                end
                                if (!s_hit_now && !r_lhit) begin
                                    r_st <= ST_NOT_FOUND;
                                end
                                r_j     <= JW'(r_lidx);
                                r_state <= r_lhit ? S_SHIFT : S_RESP;
                            end
                            default: r_state <= S_CDEC;
                        endcase
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_SHIFT: begin
                    // close the gap one slot per cycle
                    if (j_next < r_count) begin
                        r_list_ep[lj] <= r_list_ep[lj_next];
                        r_j <= r_j + JW'(1);
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_RESP;
                    end
                end
                S_CLOAD: begin
                    r_key   <= r_list_ep[r_i[LIW-1:0]];
                    r_j     <= '0;
                    r_shit  <= 1'b0;
                    r_sexp  <= 1'b0;
                    r_ffree <= 1'b0;
                    r_state <= S_SSCAN;
                end
                S_CDEC: begin
                    if (!(fail && r_pend && !out_free)) begin
                        if (fail) begin
                            if (r_pend) begin
                                r_ov       <= 1'b1;
                                r_o_status <= ST_OK;
                                r_o_alive  <= 1'b0;
                                r_o_fv     <= 1'b1;
                                r_o_ep     <= r_pend_ep;
                                r_o_last   <= 1'b0;
                            end
                            r_pend    <= 1'b1;
                            r_pend_ep <= r_key;
                        end else begin
                            r_list_ep[r_wp[LIW-1:0]] <= r_key;
                            r_wp <= r_wp + CW'(1);
                        end
                        r_i     <= r_i + CW'(1);
                        r_state <= (r_i + CW'(1) == r_count) ? S_CEND : S_CLOAD;
                    end
                end
                S_CEND: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= ST_OK;
                        r_o_alive  <= 1'b0;
                        r_o_fv     <= r_pend;
                        r_o_ep     <= r_pend ? r_pend_ep : '0;
                        r_o_last   <= 1'b1;
                        r_count    <= r_wp;
                        r_pend     <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_st;
                        r_o_alive  <= r_alive;
                        r_o_fv     <= 1'b0;
                        r_o_ep     <= '0;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // node list never exceeds its size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("node count overflow");

    // compaction write pointer never passes the read slot
    a_wp_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CDEC || r_state == S_CLOAD) |-> r_wp <= r_i)
        else $error("compaction pointer ahead of sweep");

    // tick advances time by one
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.operation == OP_TICK) |=> r_time == $past(r_time) + TIME_WIDTH'(1))
        else $error("tick did not advance time");

    // pending failed node only exists during a sweep
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("pending failed node left over");
endmodule

### verif/plt_liveness_checker.sv
// watches the three channels, predicts every result word and compares in order
module plt_liveness_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    plt_in_if    i_in,
    plt_out_if   i_out,
    plt_cfg_if   i_cfg,
    output int   o_fail_cnt,
    output int   o_pending
);
    import plt_pkg::*;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic              alive;
        logic              failed_valid;
        logic [IP_W-1:0]   failed_ip;
        logic [PORT_W-1:0] failed_port;
        logic              last;
    } t_word;

    // predicted table state
    logic [TO_W-1:0]       timeout_ticks;
    logic                  node_v  [MAX_NODES];
    logic [EP_W-1:0]       node_ep [MAX_NODES];
    logic                  heard_v [MAX_TRACKED];
    logic [EP_W-1:0]       heard_ep[MAX_TRACKED];
    logic [TIME_WIDTH-1:0] heard_at[MAX_TRACKED];
    logic [TIME_WIDTH-1:0] now_ticks;

    t_word expected_words[$];

    function automatic int node_slot(logic [EP_W-1:0] ep);
        for (int i = 0; i < MAX_NODES; i++)
            if (node_v[i] && node_ep[i] == ep) return i;
        return -1;
    endfunction

    function automatic int heard_slot(logic [EP_W-1:0] ep);
        for (int i = 0; i < MAX_TRACKED; i++)
            if (heard_v[i] && heard_ep[i] == ep) return i;
        return -1;
    endfunction

    function automatic bit is_stale(int s);
        logic [TIME_WIDTH-1:0] age;
        age = now_ticks - heard_at[s];
        return age >= TIME_WIDTH'(timeout_ticks);
    endfunction

    // removal keeps the node list packed
    task automatic drop_node(int at);
        for (int i = at; i + 1 < MAX_NODES; i++) begin
            node_v[i]  = node_v[i+1];
            node_ep[i] = node_ep[i+1];
        end
        node_v[MAX_NODES-1]  = 1'b0;
        node_ep[MAX_NODES-1] = '0;
    endtask

    task automatic push_word(logic [ST_W-1:0] st, logic al, logic fv, logic [EP_W-1:0] ep,
                             logic lst);
        t_word w;
        w.status       = st;
        w.alive        = al;
        w.failed_valid = fv;
        w.failed_ip    = ep[EP_W-1:PORT_W];
        w.failed_port  = ep[PORT_W-1:0];
        w.last         = lst;
        expected_words = {expected_words, w};
    endtask

    task automatic predict_op(logic [OP_W-1:0] op, logic [EP_W-1:0] ep);
        int li;
        int si;
        int n;
        logic [EP_W-1:0] stale_ep[$];
        logic            stale[MAX_NODES];
        case (op)
            OP_ADD: begin
                n = 0;
                for (int i = 0; i < MAX_NODES; i++) if (node_v[i]) n++;
                if (node_slot(ep) >= 0) begin
                    push_word(ST_DUPLICATE, 1'b0, 1'b0, '0, 1'b1);
                end else if (n >= MAX_NODES) begin
                    push_word(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    node_v[n]  = 1'b1;
                    node_ep[n] = ep;
                    push_word(ST_OK, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            OP_REMOVE: begin
                li = node_slot(ep);
                si = heard_slot(ep);
                if (li >= 0) drop_node(li);
                if (si >= 0) heard_v[si] = 1'b0;
                push_word((li >= 0 || si >= 0) ? ST_OK : ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
            end
            OP_HEARTBEAT: begin
                si = heard_slot(ep);
                if (si < 0) begin
                    for (int i = 0; i < MAX_TRACKED; i++)
                        if (!heard_v[i]) begin
                            si = i;
                            break;
                        end
                    if (si >= 0) begin
                        heard_v[si]  = 1'b1;
                        heard_ep[si] = ep;
                    end
                end
                if (si < 0) begin
                    push_word(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    heard_at[si] = now_ticks;
                    push_word(ST_OK, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            OP_TICK: begin
                now_ticks = now_ticks + 1'b1;
                push_word(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
            OP_CHECK: begin
                // sweep in list order, then drop from the top down
                for (int i = 0; i < MAX_NODES; i++) begin
                    stale[i] = 1'b0;
                    if (node_v[i]) begin
                        si = heard_slot(node_ep[i]);
                        if (si >= 0 && is_stale(si)) begin
                            stale[i] = 1'b1;
                            stale_ep = {stale_ep, node_ep[i]};
                        end
                    end
                end
                if (stale_ep.size() == 0) begin
                    push_word(ST_OK, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    for (int i = MAX_NODES - 1; i >= 0; i--) if (stale[i]) drop_node(i);
                    foreach (stale_ep[k])
                        push_word(ST_OK, 1'b0, 1'b1, stale_ep[k], k == stale_ep.size() - 1);
                end
            end
            OP_QUERY: begin
                si = heard_slot(ep);
                push_word(ST_OK, (si < 0 || !is_stale(si)), 1'b0, '0, 1'b1);
            end
            default: begin
                push_word(ST_OK, 1'b0, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        o_fail_cnt++;
    endtask

    task automatic compare_word();
        t_word w;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", i_out.status, 0);
            return;
        end
        w = expected_words.pop_front();
        if (i_out.status !== w.status) report_mismatch("status", i_out.status, w.status);
        if (i_out.alive !== w.alive) report_mismatch("alive", i_out.alive, w.alive);
        if (i_out.failed_valid !== w.failed_valid)
            report_mismatch("failed_valid", i_out.failed_valid, w.failed_valid);
        if (i_out.failed_ip !== w.failed_ip)
            report_mismatch("failed_ip", i_out.failed_ip, w.failed_ip);
        if (i_out.failed_port !== w.failed_port)
            report_mismatch("failed_port", i_out.failed_port, w.failed_port);
        if (i_out.last !== w.last) report_mismatch("last", i_out.last, w.last);
    endtask

    // sample all handshakes at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_cnt    = 0;
            timeout_ticks = TO_W'(30);
            now_ticks     = '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                node_v[i]  = 1'b0;
                node_ep[i] = '0;
            end
            for (int i = 0; i < MAX_TRACKED; i++) begin
                heard_v[i]  = 1'b0;
                heard_ep[i] = '0;
                heard_at[i] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) timeout_ticks = i_cfg.data;
            if (i_out.valid && i_out.ready) compare_word();
            if (i_in.valid && i_in.ready)
                predict_op(i_in.operation, {i_in.endpoint_ip, i_in.endpoint_port});
        end
        o_pending = expected_words.size();
    end

endmodule

### verif/tb_top.sv
module tb_top;
    import plt_pkg::*;

    // codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int POOL_N = 20;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    bit   steady;       // no idling on either side
    int   hold_req;     // bumped to ask the receiver for a long hold
    int   hold_seen;
    int   hold_left;

    logic [IP_W-1:0]   pool_ip  [POOL_N];
    logic [PORT_W-1:0] pool_port[POOL_N];

    plt_in_if  in_ch();
    plt_out_if out_ch();
    plt_cfg_if cfg_ch();

    peer_liveness_timeout_table_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    plt_liveness_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_fail_cnt(fail_cnt),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // result receiver: random stalls plus an occasional long hold
    initial begin
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // one word to the block, with an optional gap in front
    task automatic send_op(logic [OP_W-1:0] op, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
        if (!steady && $urandom_range(0, 99) < 35) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.endpoint_ip   <= ip;
        in_ch.endpoint_port <= port;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_timeout(logic [TO_W-1:0] ticks);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= ticks;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_pool(logic [OP_W-1:0] op, int k);
        send_op(op, pool_ip[k], pool_port[k]);
    endtask

    // mostly known endpoints so that tables fill, duplicates and expiry happen
    task automatic random_ops(int count);
        int w;
        int k;
        logic [OP_W-1:0] op;
        repeat (count) begin
            w = $urandom_range(0, 99);
            if      (w < 22) op = OP_ADD;
            else if (w < 44) op = OP_HEARTBEAT;
            else if (w < 66) op = OP_TICK;
            else if (w < 76) op = OP_CHECK;
            else if (w < 88) op = OP_QUERY;
            else if (w < 96) op = OP_REMOVE;
            else             op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
            if ($urandom_range(0, 99) < 85) begin
                k = $urandom_range(0, POOL_N - 1);
                send_op(op, pool_ip[k], pool_port[k]);
            end else begin
                send_op(op, $urandom, 16'($urandom));
            end
        end
    endtask

    initial begin
        steady        = 1'b0;
        hold_req      = 0;
        in_ch.valid   = 1'b0;
        in_ch.operation     = '0;
        in_ch.endpoint_ip   = '0;
        in_ch.endpoint_port = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;
        pool_ip[0]   = '0;
        pool_port[0] = '0;
        pool_ip[1]   = '1;
        pool_port[1] = '1;
        for (int i = 2; i < POOL_N; i++) begin
            pool_ip[i]   = $urandom;
            pool_port[i] = 16'($urandom);
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset timeout
        send_pool(OP_QUERY, 3);             // untracked counts as alive
        send_pool(OP_REMOVE, 3);            // in neither table
        send_pool(OP_ADD, 0);
        send_pool(OP_ADD, 1);
        send_pool(OP_ADD, 0);               // duplicate
        send_pool(OP_HEARTBEAT, 2);         // sender not in the list
        send_pool(OP_HEARTBEAT, 0);
        send_pool(OP_TICK, 0);
        send_op(OP_SPARE6, '1, '1);
        send_op(OP_SPARE7, 32'h5a5a_a5a5, 16'ha5a5);
        send_pool(OP_QUERY, 0);
        send_pool(OP_CHECK, 0);             // nothing stale, node 1 never heard
        set_timeout(16'd1);
        send_pool(OP_HEARTBEAT, 1);
        send_pool(OP_TICK, 0);
        send_pool(OP_QUERY, 1);             // stale now
        send_pool(OP_CHECK, 0);             // two failed nodes
        send_pool(OP_REMOVE, 2);            // only in the heard table
        set_timeout(16'd0);                 // everything heard counts as failed
        send_pool(OP_ADD, 2);
        send_pool(OP_HEARTBEAT, 2);
        send_pool(OP_QUERY, 2);
        send_pool(OP_CHECK, 0);

        // random phases over several timeouts
        set_timeout(16'd3);
        random_ops(45);
        set_timeout(16'd0);
        random_ops(20);
        set_timeout(16'hffff);
        random_ops(25);
        set_timeout(16'd1);
        steady = 1'b1;
        random_ops(40);
        steady = 1'b0;
        set_timeout(16'd2);

        // long receiver hold while items keep coming
        hold_req = hold_req + 1;
        random_ops(25);
        drain();

        if (fail_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
